/* hw/rtl/smm_pkg.sv */
// Shared types and constants of the segmented memory manager.
// No dependencies; compiled first.
`default_nettype none

package smm_pkg;

  localparam int KIND_W   = 3;
  localparam int SEG_ID_W = 8;
  localparam int OFFSET_W = 10;
  localparam int VALUE_W  = 32;
  localparam int SIZE_W   = 11;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAP       = 3'd0,
    KIND_UNMAP     = 3'd1,
    KIND_STORE     = 3'd2,
    KIND_LOAD      = 3'd3,
    KIND_LOAD_PROG = 3'd4,
    KIND_PRELOAD   = 3'd5
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_ID     = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_UNMAPPED  = 3'd3,
    STAT_BEYOND    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FILL,
    ST_COPY,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/smm_if.sv */
// Request and response channel interfaces of the segmented memory manager.
// Depends on smm_pkg.
`default_nettype none

interface smm_req_if;
  logic                          valid;
  logic                          ready;
  logic [smm_pkg::KIND_W-1:0]    kind;
  logic [smm_pkg::SEG_ID_W-1:0]  seg_id;
  logic [smm_pkg::OFFSET_W-1:0]  offset;
  logic [smm_pkg::VALUE_W-1:0]   value;
  logic [smm_pkg::SIZE_W-1:0]    size;

  modport source (output valid, kind, seg_id, offset, value, size, input ready);
  modport sink   (input valid, kind, seg_id, offset, value, size, output ready);
endinterface

interface smm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [smm_pkg::DATA_W-1:0]    data;
  logic [smm_pkg::STATUS_W-1:0]  status;

  modport source (output valid, data, status, input ready);
  modport sink   (input valid, data, status, output ready);
endinterface

`default_nettype wire

/* hw/rtl/smm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module smm_ram #(
  parameter int     WIDTH = 32,
  parameter longint DEPTH = 1024,
  parameter int     AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/segmented_memory_manager.sv */
// Segmented word memory: top level with segment table, free-id stack and word store.
// Depends on smm_pkg, smm_if (smm_req_if, smm_rsp_if) and smm_ram.
//
// Usage: requests enter on req (map, unmap, store, load, load program, preload
// of segment 0); each gives exactly one response on rsp with data and status.
// After reset the segment table is swept once, entry by entry, with
// req.ready low; segment 0 comes out mapped and empty, all others unmapped.
// One request is in work at a time; req.ready is high in the idle state even
// while a response waits in the output register.
// Steps from accept to response valid:
//   errors, unmap, store, unknown kinds, load program of segment 0: look, done
//   load: look, read, done
//   map: look, zero fill (one word a cycle), table write, done
//   load program of another segment: look, pipelined copy, table write, done
//   preload: look, zero fill of the words from the length up to the offset, done
// Fill and copy speed is set by the single write port of the word store.
// The next request is taken in the cycle after the response is registered.
// If rsp stalls, the finished response waits in the done state until the
// output register frees up; no response is dropped or repeated.
`default_nettype none

module segmented_memory_manager #(
  parameter int MAX_SEGMENTS = 256,
  parameter int SEG_WORDS    = 1024
) (
  input  logic         clk,
  input  logic         rst,
  smm_req_if.sink      req,
  smm_rsp_if.source    rsp
);

  localparam int     SEG_W  = $clog2(MAX_SEGMENTS);
  localparam int     LEN_W  = $clog2(SEG_WORDS + 1);
  localparam int     FC_W   = $clog2(MAX_SEGMENTS + 1);
  localparam longint WORDS  = longint'(MAX_SEGMENTS) * longint'(SEG_WORDS);
  localparam int     ADDR_W = $clog2(WORDS);
  localparam int     ENT_W  = LEN_W + 1;

  smm_pkg::state_t  state, state_next;
  logic [SEG_W-1:0] clr_idx, clr_idx_next;

  logic [smm_pkg::KIND_W-1:0]   r_kind;
  logic [smm_pkg::SEG_ID_W-1:0] r_seg;
  logic [smm_pkg::OFFSET_W-1:0] r_off;
  logic [smm_pkg::VALUE_W-1:0]  r_val;
  logic [smm_pkg::SIZE_W-1:0]   r_size;

  logic [FC_W-1:0]  free_count, free_count_next;
  logic [FC_W-1:0]  next_id, next_id_next;
  logic [SEG_W-1:0] cur_id, cur_id_next;
  logic [LEN_W-1:0] cnt, cnt_next;
  logic [LEN_W-1:0] cnt_end, cnt_end_next;
  logic             copy_pend, copy_pend_next;
  logic [LEN_W-1:0] copy_off, copy_off_next;
  logic [ENT_W-1:0] ent_pend, ent_pend_next;

  logic [smm_pkg::DATA_W-1:0]   res_data, res_data_next;
  smm_pkg::status_t             res_status, res_status_next;
  logic                         out_valid, out_valid_next;
  logic [smm_pkg::DATA_W-1:0]   out_data, out_data_next;
  logic [smm_pkg::STATUS_W-1:0] out_status, out_status_next;

  logic              tbl_we;
  logic [SEG_W-1:0]  tbl_waddr, tbl_raddr;
  logic [ENT_W-1:0]  tbl_wdata, tbl_rdata;
  logic              stk_we;
  logic [SEG_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;
  logic              wrd_we;
  logic [ADDR_W-1:0] wrd_waddr, wrd_raddr;
  logic [31:0]       wrd_wdata, wrd_rdata;

  logic             ent_mapped;
  logic [LEN_W-1:0] ent_len;
  logic [SEG_W-1:0] r_seg_idx;
  logic             seg_live;
  logic             off_beyond;

  function automatic logic [ADDR_W-1:0] word_addr(input logic [SEG_W-1:0] s,
                                                  input logic [LEN_W-1:0] o);
    return ADDR_W'(s) * ADDR_W'(SEG_WORDS) + ADDR_W'(o);
  endfunction

  // segment table entry: {mapped, length}
  smm_ram #(.WIDTH(ENT_W), .DEPTH(MAX_SEGMENTS), .AW(SEG_W)) u_seg_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  smm_ram #(.WIDTH(SEG_W), .DEPTH(MAX_SEGMENTS), .AW(SEG_W)) u_free_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  smm_ram #(.WIDTH(32), .DEPTH(WORDS), .AW(ADDR_W)) u_words (
    .clk(clk), .we(wrd_we), .waddr(wrd_waddr), .wdata(wrd_wdata),
    .raddr(wrd_raddr), .rdata(wrd_rdata)
  );

  assign ent_mapped = tbl_rdata[LEN_W];
  assign ent_len    = tbl_rdata[LEN_W-1:0];
  assign r_seg_idx  = SEG_W'(r_seg);
  assign seg_live   = (32'(r_seg) < MAX_SEGMENTS) && ent_mapped;
  assign off_beyond = 32'(r_off) >= 32'(ent_len);

  assign req.ready  = (state == smm_pkg::ST_IDLE);
  assign rsp.valid  = out_valid;
  assign rsp.data   = out_data;
  assign rsp.status = out_status;

  always_comb begin
    state_next      = state;
    clr_idx_next    = clr_idx;
    free_count_next = free_count;
    next_id_next    = next_id;
    cur_id_next     = cur_id;
    cnt_next        = cnt;
    cnt_end_next    = cnt_end;
    copy_pend_next  = copy_pend;
    copy_off_next   = copy_off;
    ent_pend_next   = ent_pend;
    res_data_next   = res_data;
    res_status_next = res_status;
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    out_status_next = out_status;

    tbl_we    = 1'b0;
    tbl_waddr = '0;
    tbl_wdata = '0;
    tbl_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = '0;
    stk_wdata = '0;
    stk_raddr = '0;
    wrd_we    = 1'b0;
    wrd_waddr = '0;
    wrd_wdata = '0;
    wrd_raddr = '0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    unique case (state)
      smm_pkg::ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_idx;
        tbl_wdata = (clr_idx == '0) ? {1'b1, LEN_W'(0)} : '0;
        if (clr_idx == SEG_W'(MAX_SEGMENTS - 1)) begin
          state_next = smm_pkg::ST_IDLE;
        end else begin
          clr_idx_next = clr_idx + SEG_W'(1);
        end
      end

      smm_pkg::ST_IDLE: begin
        tbl_raddr = (req.kind == smm_pkg::KIND_PRELOAD) ? '0 : SEG_W'(req.seg_id);
        stk_raddr = SEG_W'(free_count - FC_W'(1));
        if (req.valid) begin
          res_data_next   = '0;
          res_status_next = smm_pkg::STAT_OK;
          state_next      = smm_pkg::ST_LOOK;
        end
      end

      smm_pkg::ST_LOOK: begin
        state_next = smm_pkg::ST_DONE;
        unique case (r_kind) inside
          smm_pkg::KIND_MAP: begin
            if (32'(r_size) > SEG_WORDS) begin
              res_status_next = smm_pkg::STAT_TOO_LARGE;
            end else if (free_count != '0) begin
              free_count_next = free_count - FC_W'(1);
              cur_id_next     = stk_rdata;
              cnt_next        = '0;
              cnt_end_next    = LEN_W'(r_size);
              ent_pend_next   = {1'b1, LEN_W'(r_size)};
              state_next      = smm_pkg::ST_FILL;
            end else if (32'(next_id) < MAX_SEGMENTS) begin
              next_id_next  = next_id + FC_W'(1);
              cur_id_next   = SEG_W'(next_id);
              cnt_next      = '0;
              cnt_end_next  = LEN_W'(r_size);
              ent_pend_next = {1'b1, LEN_W'(r_size)};
              state_next    = smm_pkg::ST_FILL;
            end else begin
              res_status_next = smm_pkg::STAT_NO_ID;
            end
          end

          smm_pkg::KIND_UNMAP: begin
            if (r_seg == '0 || !seg_live) begin
              res_status_next = smm_pkg::STAT_UNMAPPED;
            end else begin
              tbl_we    = 1'b1;
              tbl_waddr = r_seg_idx;
              tbl_wdata = '0;
              if (32'(free_count) < MAX_SEGMENTS) begin
                stk_we          = 1'b1;
                stk_waddr       = SEG_W'(free_count);
                stk_wdata       = r_seg_idx;
                free_count_next = free_count + FC_W'(1);
              end
            end
          end

          smm_pkg::KIND_STORE, smm_pkg::KIND_LOAD: begin
            if (!seg_live) begin
              res_status_next = smm_pkg::STAT_UNMAPPED;
            end else if (off_beyond) begin
              res_status_next = smm_pkg::STAT_BEYOND;
            end else if (r_kind == smm_pkg::KIND_STORE) begin
              wrd_we    = 1'b1;
              wrd_waddr = word_addr(r_seg_idx, LEN_W'(r_off));
              wrd_wdata = r_val;
            end else begin
              wrd_raddr  = word_addr(r_seg_idx, LEN_W'(r_off));
              state_next = smm_pkg::ST_READ;
            end
          end

          smm_pkg::KIND_LOAD_PROG: begin
            if (!seg_live) begin
              res_status_next = smm_pkg::STAT_UNMAPPED;
            end else begin
              res_data_next = 32'(r_off);
              if (r_seg != '0) begin
                cur_id_next    = r_seg_idx;
                cnt_next       = '0;
                cnt_end_next   = ent_len;
                ent_pend_next  = {1'b1, ent_len};
                copy_pend_next = 1'b0;
                state_next     = smm_pkg::ST_COPY;
              end
            end
          end

          smm_pkg::KIND_PRELOAD: begin
            if (32'(r_off) >= SEG_WORDS) begin
              res_status_next = smm_pkg::STAT_BEYOND;
            end else begin
              cur_id_next   = '0;
              cnt_next      = ent_len;
              cnt_end_next  = LEN_W'(r_off);
              ent_pend_next = {1'b1, (32'(ent_len) > 32'(r_off)) ? ent_len
                                                                 : LEN_W'(32'(r_off) + 1)};
              state_next    = smm_pkg::ST_FILL;
            end
          end

          default: begin
            state_next = smm_pkg::ST_DONE;
          end
        endcase
      end

      smm_pkg::ST_FILL: begin
        if (cnt < cnt_end) begin
          wrd_we    = 1'b1;
          wrd_waddr = word_addr(cur_id, cnt);
          wrd_wdata = '0;
          cnt_next  = cnt + LEN_W'(1);
        end else begin
          tbl_we    = 1'b1;
          tbl_waddr = cur_id;
          tbl_wdata = ent_pend;
          if (r_kind == smm_pkg::KIND_PRELOAD) begin
            wrd_we    = 1'b1;
            wrd_waddr = word_addr('0, LEN_W'(r_off));
            wrd_wdata = r_val;
          end else begin
            res_data_next = 32'(cur_id);
          end
          state_next = smm_pkg::ST_DONE;
        end
      end

      smm_pkg::ST_COPY: begin
        // read word i while word i-1 lands in segment 0
        if (copy_pend) begin
          wrd_we    = 1'b1;
          wrd_waddr = word_addr('0, copy_off);
          wrd_wdata = wrd_rdata;
        end
        if (cnt < cnt_end) begin
          wrd_raddr      = word_addr(cur_id, cnt);
          copy_off_next  = cnt;
          copy_pend_next = 1'b1;
          cnt_next       = cnt + LEN_W'(1);
        end else begin
          copy_pend_next = 1'b0;
          if (!copy_pend) begin
            tbl_we     = 1'b1;
            tbl_waddr  = '0;
            tbl_wdata  = ent_pend;
            state_next = smm_pkg::ST_DONE;
          end
        end
      end

      smm_pkg::ST_READ: begin
        res_data_next = wrd_rdata;
        state_next    = smm_pkg::ST_DONE;
      end

      smm_pkg::ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_data_next   = res_data;
          out_status_next = res_status;
          state_next      = smm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = smm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= smm_pkg::ST_CLEAR;
      clr_idx    <= '0;
      free_count <= '0;
      next_id    <= FC_W'(1);
      copy_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_idx    <= clr_idx_next;
      free_count <= free_count_next;
      next_id    <= next_id_next;
      copy_pend  <= copy_pend_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      r_kind <= req.kind;
      r_seg  <= req.seg_id;
      r_off  <= req.offset;
      r_val  <= req.value;
      r_size <= req.size;
    end
    cur_id     <= cur_id_next;
    cnt        <= cnt_next;
    cnt_end    <= cnt_end_next;
    copy_off   <= copy_off_next;
    ent_pend   <= ent_pend_next;
    res_data   <= res_data_next;
    res_status <= res_status_next;
    out_data   <= out_data_next;
    out_status <= out_status_next;
  end

  a_free_below_next: assert property (@(posedge clk) disable iff (rst)
    free_count < next_id)
    else $error("free stack holds more ids than were ever handed out");

  a_next_bound: assert property (@(posedge clk) disable iff (rst)
    32'(next_id) <= MAX_SEGMENTS)
    else $error("next unused id ran past the segment count");

  a_copy_target: assert property (@(posedge clk) disable iff (rst)
    (state == smm_pkg::ST_COPY && wrd_we) |-> (64'(wrd_waddr) < 64'(SEG_WORDS)))
    else $error("program copy wrote outside segment 0");

  a_stack_push: assert property (@(posedge clk) disable iff (rst)
    stk_we |-> (state == smm_pkg::ST_LOOK && r_kind == smm_pkg::KIND_UNMAP))
    else $error("free stack written outside an unmap");

endmodule

`default_nettype wire
